[rtl/core/tcw_pkg.sv]
// Shared constants and sequencer state type for the text console writer.
package tcw_pkg;

    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 4;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_BLANK   = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'd7;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam int CELL_W = 16;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PUT,
        ST_LINE,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } state_t;

endpackage

[rtl/core/text_console_writer_core.sv]
// Text console writer: screen cell store, cursor sequencer and result register.
// Steps: a read item goes through ST_READ into the result register; a put through ST_PUT
//   (held there while a tab writes blanks) or ST_LINE (newline) and ST_DONE; a line end
//   in the last row adds ST_SCROLL and ST_BLANK (one store cell moved or blanked per cycle).
// Throughput: one item at a time; in_ready is low until the item's result is loaded.
// Reset: rst_n (async, active low) clears cursor, color (to 7) and control; then a
//   clearing pass writes blank cells to the whole store before the first item.
module text_console_writer_core #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        text_color_we,
    input  logic [7:0]  text_color,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_address,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] cell_data,
    output logic [10:0] cursor_index
);

    import tcw_pkg::*;

    localparam int CELL_COUNT  = ROWS * COLUMNS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int ROW_W       = $clog2(ROWS);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int TAB_W       = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int SCROLL_LAST = CELL_COUNT - COLUMNS;

    // Sequencer and cursor state
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ADDR_W-1:0]   base_reg, base_next;     // row_reg * COLUMNS, kept by adding
    logic [TAB_W-1:0]    phase_reg, phase_next;   // col_reg modulo TAB_STOP
    logic [7:0]          color_reg;

    // Latched item
    logic [7:0]          ch_reg;
    logic                is_tab_reg;
    logic                rd_ok_reg;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]   cell_data_reg, cell_data_next;
    logic [10:0]         loc_reg, loc_next;

    // Store port
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [CELL_W-1:0]   mem_wdata, mem_rdata;

    logic                accept;
    logic                col_last, row_last, line_end, phase_wrap, tab_more;
    logic [ADDR_W-1:0]   cursor_pos;
    logic [COL_W-1:0]    col_inc;
    logic [TAB_W-1:0]    phase_inc;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Take a new item only when idle and the result register is free by the next edge
    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept     = in_valid && in_ready;

    assign cursor_pos = base_reg + ADDR_W'(col_reg);
    assign col_last   = (col_reg == COL_W'(COLUMNS - 1));
    assign row_last   = (row_reg == ROW_W'(ROWS - 1));
    assign col_inc    = col_reg + COL_W'(1);
    assign phase_wrap = (phase_reg == TAB_W'(TAB_STOP - 1));
    assign phase_inc  = phase_wrap ? '0 : (phase_reg + TAB_W'(1));
    // A tab keeps writing blanks until the column lands on a stop
    assign tab_more   = is_tab_reg && !phase_wrap;
    // Line end: newline, or a write in the last column
    assign line_end   = (state_reg == ST_LINE) || ((state_reg == ST_PUT) && col_last);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (char_code == CHAR_NEWLINE)
                    begin
                        state_next = ST_LINE;
                    end
                    else
                    begin
                        state_next = ST_PUT;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_PUT, ST_LINE:
            begin
                if (line_end)
                begin
                    state_next = row_last ? ST_SCROLL : ST_DONE;
                end
                else if (!tab_more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL:
            begin
                if (cnt_reg == ADDR_W'(SCROLL_LAST))
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, store port and result controls
    always_comb
    begin
        cnt_next       = cnt_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cell_data_next = cell_data_reg;
        loc_next       = loc_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg;
        mem_wdata      = {color_reg, CHAR_BLANK};
        mem_re         = 1'b0;
        mem_raddr      = ADDR_W'(cell_address);
        case (state_reg)
            ST_CLEAR:
            begin
                // Fill with the reset blank, independent of any color write meanwhile
                mem_we    = 1'b1;
                mem_wdata = {ATTR_RESET, CHAR_BLANK};
                cnt_next  = cnt_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                mem_re = accept && (operation == OP_READ);
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                cell_data_next = rd_ok_reg ? mem_rdata : '0;
                loc_next       = 11'(cursor_pos);
            end
            ST_PUT, ST_LINE:
            begin
                if (state_reg == ST_PUT)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cursor_pos;
                    mem_wdata = {color_reg, ch_reg};
                end
                if (line_end)
                begin
                    col_next   = '0;
                    phase_next = '0;
                    cnt_next   = '0;
                    if (!row_last)
                    begin
                        row_next  = row_reg + ROW_W'(1);
                        base_next = base_reg + ADDR_W'(COLUMNS);
                    end
                end
                else
                begin
                    col_next   = col_inc;
                    phase_next = phase_inc;
                end
            end
            ST_SCROLL:
            begin
                // Read one row ahead, write the word fetched last cycle one cell behind
                mem_re    = (cnt_reg != ADDR_W'(SCROLL_LAST));
                mem_raddr = cnt_reg + ADDR_W'(COLUMNS);
                mem_we    = (cnt_reg != '0);
                mem_waddr = cnt_reg - ADDR_W'(1);
                mem_wdata = mem_rdata;
                if (cnt_reg != ADDR_W'(SCROLL_LAST))
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_BLANK:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + ADDR_W'(1);
            end
            ST_DONE:
            begin
                out_valid_next = 1'b1;
                cell_data_next = '0;
                loc_next       = 11'(cursor_pos);
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            phase_reg     <= '0;
            color_reg     <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (text_color_we)
            begin
                color_reg <= text_color;
            end
        end
    end

    // Payload registers: latch the item at accept, hold the result until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg     <= (char_code == CHAR_TAB) ? CHAR_BLANK : char_code;
            is_tab_reg <= (char_code == CHAR_TAB);
            rd_ok_reg  <= (32'(cell_address) < 32'(CELL_COUNT));
        end
        cell_data_reg <= cell_data_next;
        loc_reg       <= loc_next;
    end

    assign out_valid    = out_valid_reg;
    assign cell_data    = cell_data_reg;
    assign cursor_index = loc_reg;

    // The result register is never overwritten while a beat is pending
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!out_valid_reg || out_ready))
        else $error("item accepted while result beat still pending");

    // Cursor stays on screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < 32'(COLUMNS)) && (32'(row_reg) < 32'(ROWS)))
        else $error("cursor off screen");

    // Row base tracks the row
    a_base_track: assert property (@(posedge clk) disable iff (!rst_n)
        32'(base_reg) == 32'(row_reg) * 32'(COLUMNS))
        else $error("row base out of step with cursor row");

    // A new result appears only from a read or a finished put
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_READ || $past(state_reg) == ST_DONE))
        else $error("result loaded outside a finishing step");

endmodule

[rtl/core/tcw_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[test/tb_text_console_writer_core.sv]
// Self-checking testbench for the text console writer core: directed and random beats.
`timescale 1ns / 1ps

module tb_text_console_writer_core;
    import tcw_pkg::*;

    localparam int COLUMNS        = COLUMNS_DEF;
    localparam int ROWS           = ROWS_DEF;
    localparam int TAB_STOP       = TAB_STOP_DEF;
    localparam int CELLS          = COLUMNS * ROWS;
    // A scroll and the clearing pass each step through every cell; the watchdog limit
    // is far above either of them and above the long receiver hold-off.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_ITEMS    = 80;
    localparam int PHASES         = 5;

    typedef struct packed {
        logic        op;
        logic [7:0]  ch;
        logic [10:0] addr;
    } console_item_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [10:0] loc;
    } console_result_t;

    // Block ports; every input starts at a known value.
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        text_color_we = 1'b0;
    logic [7:0]  text_color    = ATTR_RESET;
    logic        in_valid      = 1'b0;
    logic        operation     = OP_PUT;
    logic [7:0]  char_code     = 8'd0;
    logic [10:0] cell_address  = 11'd0;
    logic        out_ready     = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [15:0] cell_data;
    logic [10:0] cursor_index;

    // Console mirror: screen, cursor and attribute as the block should hold them.
    logic [15:0]  screen_mirror [CELLS];
    int unsigned  mirror_row;
    int unsigned  mirror_col;
    logic [7:0]   color_mirror;

    console_item_t   pending_items [$];
    console_result_t expected_results [$];

    // Handshake bookkeeping for the driver, the receiver and the monitor.
    logic in_took       = 1'b0;
    bit   idling_on     = 1'b1;
    bit   long_hold_req = 1'b0;
    int   send_gap      = 0;
    int   send_quiet    = 0;
    int   recv_gap      = 0;
    int   recv_quiet    = 0;
    int   hold_left     = 0;
    int   idle_cycles   = 0;

    int put_count      = 0;
    int read_count     = 0;
    int scroll_count   = 0;
    int color_writes   = 0;
    int checked_count  = 0;
    int mismatch_count = 0;

    text_console_writer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_color_we (text_color_we),
        .text_color    (text_color),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .char_code     (char_code),
        .cell_address  (cell_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cell_data     (cell_data),
        .cursor_index  (cursor_index)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Console mirror
    // ------------------------------------------------------------------

    // Move to column 0 of the next row; past the last row shift every row up
    // and blank the bottom one in the current attribute.
    task automatic mirror_line_feed();
        mirror_col = 0;
        mirror_row++;
        if (mirror_row >= ROWS)
        begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen_mirror[i] = screen_mirror[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen_mirror[i] = {color_mirror, CHAR_BLANK};
            mirror_row = ROWS - 1;
            scroll_count++;
        end
    endtask

    // Store one byte at the cursor as is, then advance and wrap at the row end.
    task automatic mirror_put(input logic [7:0] ch);
        screen_mirror[mirror_row * COLUMNS + mirror_col] = {color_mirror, ch};
        mirror_col++;
        if (mirror_col >= COLUMNS)
            mirror_line_feed();
    endtask

    // Apply one accepted beat to the mirror and work out the result it owes.
    task automatic predict_console(input console_item_t item, output console_result_t res);
        res.cell_value = '0;
        if (item.op == OP_READ)
        begin
            read_count++;
            // Addresses past the screen read as zero.
            if (item.addr < CELLS)
                res.cell_value = screen_mirror[item.addr];
        end
        else
        begin
            put_count++;
            if (item.ch == CHAR_NEWLINE)
                mirror_line_feed();
            else if (item.ch == CHAR_TAB)
            begin
                // Always at least one blank; a wrap lands on column 0 and ends the tab.
                mirror_put(CHAR_BLANK);
                while (mirror_col % TAB_STOP != 0)
                    mirror_put(CHAR_BLANK);
            end
            else
                mirror_put(item.ch);
        end
        res.loc = 11'(mirror_row * COLUMNS + mirror_col);
    endtask

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] MISMATCH %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        console_item_t   seen_item;
        console_result_t fresh;
        console_result_t oldest;
        logic            beat;
        if (rst_n)
        begin
            beat = 1'b0;
            in_took <= in_valid && in_ready;

            // Check the result beat against the oldest expectation.
            if (out_valid && out_ready)
            begin
                beat = 1'b1;
                checked_count++;
                if (expected_results.size() == 0)
                    note_mismatch($sformatf(
                        "result with nothing expected: cell_data 0x%04h cursor %0d",
                        cell_data, cursor_index));
                else
                begin
                    oldest = expected_results.pop_front();
                    if (cell_data !== oldest.cell_value)
                        note_mismatch($sformatf("cell_data expected 0x%04h got 0x%04h",
                                                oldest.cell_value, cell_data));
                    if (cursor_index !== oldest.loc)
                        note_mismatch($sformatf("cursor_index expected %0d got %0d",
                                                oldest.loc, cursor_index));
                end
            end

            // Predict on the input beat; order against the result beat does not
            // matter since the queue is first in, first out.
            if (in_valid && in_ready)
            begin
                beat = 1'b1;
                seen_item.op   = operation;
                seen_item.ch   = char_code;
                seen_item.addr = cell_address;
                predict_console(seen_item, fresh);
                expected_results.push_back(fresh);
            end

            // Watchdog: give up after a long stretch with no beat on either side.
            if (beat)
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Watchdog: %0d cycles without a beat, %0d results outstanding",
                             idle_cycles, expected_results.size());
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: present pending items at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_items
        console_item_t next_item;
        logic          offer;
        // Hold valid and payload until the beat is taken.
        if (rst_n && (!in_valid || in_took))
        begin
            offer = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (idling_on && send_quiet == 0 && $urandom_range(0, 6) == 0)
                send_gap = $urandom_range(0, 10);
            else if (pending_items.size() != 0)
            begin
                next_item = pending_items.pop_front();
                offer = 1'b1;
                operation    <= next_item.op;
                char_code    <= next_item.ch;
                cell_address <= next_item.addr;
            end
            // Now and then run a stretch with no gaps at all.
            if (send_quiet > 0)
                send_quiet--;
            else if ($urandom_range(0, 60) == 0)
                send_quiet = $urandom_range(30, 120);
            in_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_ready
        logic take;
        take = 1'b1;
        if (long_hold_req)
        begin
            hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            take = 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            take = 1'b0;
        end
        else if (idling_on && recv_quiet == 0 && $urandom_range(0, 5) == 0)
        begin
            recv_gap = $urandom_range(0, 10);
            take = 1'b0;
        end
        if (recv_quiet > 0)
            recv_quiet--;
        else if ($urandom_range(0, 60) == 0)
            recv_quiet = $urandom_range(30, 120);
        out_ready <= take;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_item(input logic op, input logic [7:0] ch, input logic [10:0] addr);
        console_item_t item;
        item.op   = op;
        item.ch   = ch;
        item.addr = addr;
        pending_items.push_back(item);
    endtask

    // Block until every queued item went in and every result came back.
    task automatic wait_until_drained();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Write the attribute register while the block sits idle.
    task automatic write_text_color(input logic [7:0] value);
        wait_until_drained();
        repeat (2) @(negedge clk);
        text_color_we <= 1'b1;
        text_color    <= value;
        @(negedge clk);
        text_color_we <= 1'b0;
        color_mirror = value;
        color_writes++;
        @(posedge clk);
    endtask

    // Random phase built from short sequences: text runs, line ends, tabs, row ends,
    // reads of the screen and some noise.
    task automatic queue_random_phase(input int target);
        int          made;
        int          kind;
        int          run;
        int unsigned col;
        logic [7:0]  ch;
        made = 0;
        while (made < target)
        begin
            kind = $urandom_range(0, 13);
            if (kind <= 4)
            begin
                // Text run: mostly printable, sometimes any byte at all.
                run = $urandom_range(1, 12);
                for (int i = 0; i < run; i++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        ch = 8'($urandom_range(0, 255));
                    else
                        ch = 8'($urandom_range(8'h21, 8'h7E));
                    queue_item(OP_PUT, ch, 11'($urandom));
                end
                made += run;
            end
            else if (kind <= 6)
            begin
                run = $urandom_range(1, 2);
                for (int i = 0; i < run; i++)
                    queue_item(OP_PUT, CHAR_NEWLINE, 11'($urandom));
                made += run;
            end
            else if (kind == 7)
            begin
                run = $urandom_range(1, 3);
                for (int i = 0; i < run; i++)
                    queue_item(OP_PUT, CHAR_TAB, 11'($urandom));
                made += run;
            end
            else if (kind <= 10)
            begin
                // Reads: whole address range, bottom row, or anywhere on screen.
                run = $urandom_range(1, 4);
                for (int i = 0; i < run; i++)
                begin
                    case ($urandom_range(0, 3))
                        0: queue_item(OP_READ, 8'($urandom), 11'($urandom_range(0, 2047)));
                        1: queue_item(OP_READ, 8'($urandom),
                                      11'((ROWS - 1) * COLUMNS + $urandom_range(0, COLUMNS - 1)));
                        default: queue_item(OP_READ, 8'($urandom),
                                            11'($urandom_range(0, CELLS - 1)));
                    endcase
                end
                made += run;
            end
            else if (kind == 11)
            begin
                // Row end: drain to learn the cursor, tab up to the last tab
                // stop, add a few bytes, then end with a tab or a line feed.
                wait_until_drained();
                col = mirror_col;
                while (col < COLUMNS - TAB_STOP)
                begin
                    queue_item(OP_PUT, CHAR_TAB, 11'($urandom));
                    col = (col / TAB_STOP + 1) * TAB_STOP;
                    made++;
                end
                run = $urandom_range(0, TAB_STOP - 1);
                for (int i = 0; i < run; i++)
                    queue_item(OP_PUT, 8'($urandom_range(8'h21, 8'h7E)), 11'($urandom));
                if ($urandom_range(0, 3) == 0)
                    queue_item(OP_PUT, CHAR_NEWLINE, 11'($urandom));
                else
                    queue_item(OP_PUT, CHAR_TAB, 11'($urandom));
                made += run + 1;
            end
            else
            begin
                // Noise: any operation, any byte, any address.
                run = $urandom_range(1, 4);
                for (int i = 0; i < run; i++)
                    queue_item(($urandom_range(0, 1) == 1) ? OP_READ : OP_PUT,
                               8'($urandom), 11'($urandom));
                made += run;
            end
        end
    endtask

    initial
    begin : run_test
        logic [7:0] phase_color;
        for (int i = 0; i < CELLS; i++)
            screen_mirror[i] = {ATTR_RESET, CHAR_BLANK};
        color_mirror = ATTR_RESET;
        mirror_row   = 0;
        mirror_col   = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset attribute: fresh screen, read range edges,
        // byte extremes, control bytes, tabs from several columns, line feed.
        queue_item(OP_READ, 8'hFF, 11'd0);
        queue_item(OP_READ, 8'h00, 11'(CELLS - 1));
        queue_item(OP_READ, 8'hA5, 11'(CELLS));
        queue_item(OP_READ, 8'h5A, 11'h7FF);
        queue_item(OP_PUT, 8'h41, 11'h7FF);
        queue_item(OP_PUT, 8'hFF, 11'h000);
        queue_item(OP_PUT, 8'h80, 11'h555);
        queue_item(OP_PUT, 8'h00, 11'h2AA);
        queue_item(OP_PUT, 8'h7F, 11'h400);
        queue_item(OP_PUT, 8'd13, 11'h3FF);
        queue_item(OP_PUT, CHAR_TAB, 11'h001);
        queue_item(OP_PUT, CHAR_TAB, 11'h002);
        queue_item(OP_PUT, 8'h78, 11'h004);
        queue_item(OP_PUT, CHAR_TAB, 11'h008);
        queue_item(OP_PUT, CHAR_NEWLINE, 11'h010);
        queue_item(OP_PUT, 8'h55, 11'h020);
        queue_item(OP_READ, 8'h00, 11'd1);
        queue_item(OP_READ, 8'h00, 11'd2);
        queue_item(OP_READ, 8'h00, 11'd5);
        queue_item(OP_READ, 8'h00, 11'd7);
        queue_item(OP_READ, 8'h00, 11'(COLUMNS));
        queue_item(OP_READ, 8'h00, 11'd1024);
        wait_until_drained();

        // Random phases, each under its own attribute. The second phase opens
        // with a long receiver hold-off; the last runs without any idling.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       phase_color = 8'hFF;
                1:       phase_color = 8'h00;
                3:       phase_color = 8'h80;
                default: phase_color = 8'($urandom);
            endcase
            write_text_color(phase_color);
            if (phase == 1)
                long_hold_req = 1'b1;
            if (phase == PHASES - 1)
                idling_on = 1'b0;
            queue_random_phase(PHASE_ITEMS);
            wait_until_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (20) @(posedge clk);

        $display("Covered %0d puts and %0d reads (%0d results checked), %0d scrolls,",
                 put_count, read_count, checked_count, scroll_count);
        $display("%0d text color settings, %0d mismatches in total.",
                 color_writes, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
